/* src/greedy_load_balance_assign_core_defines.svh */
// assertion macros used by the checker
`ifndef GREEDY_LOAD_BALANCE_ASSIGN_CORE_DEFINES_SVH
`define GREEDY_LOAD_BALANCE_ASSIGN_CORE_DEFINES_SVH

// checked on every edge outside reset
`define GLBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define GLBA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/glba_pkg.sv */
// types and fixed widths for the greedy load balancing assigner
package glba_pkg;

    localparam int WEIGHT_W    = 31;
    localparam int LOAD_W      = 37;
    localparam int JOB_INDEX_W = 6;
    localparam int WORKER_W    = 4;
    localparam int PROCS_W     = 5;

    localparam logic [PROCS_W-1:0] PROCS_RESET = 5'd2;

    // one sort entry: arrival index and its weight
    typedef struct packed {
        logic [JOB_INDEX_W-1:0] idx;
        logic [WEIGHT_W-1:0]    weight;
    } job_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_I,
        ST_SORT_CUR,
        ST_SORT_CMP,
        ST_SORT_WB,
        ST_ASN_READ,
        ST_ASN_LOAD,
        ST_ASN_SCAN,
        ST_ASN_UPDATE,
        ST_OUT_READ,
        ST_OUT_SHOW
    } state_t;

endpackage

/* src/greedy_load_balance_assign_core.sv */
// Greedy load balancing job assigner (longest processing time first). Job weights
// are taken one request per cycle while the block is idle and stored in arrival
// order; requests beyond MAX_JOBS are dropped and flagged. A request with last_job
// closes the batch and in_ready falls until the last result has been taken. The
// batch of n jobs is then ordered by an exchange sort through one read and one
// write port of the job memory, one compare per cycle. Each job then walks the
// worker loads with a single comparator. Results come out in arrival order, each
// held until out_ready takes it. The num_procs register may be written at any
// time the block is idle; cfg_ready is always high.
module greedy_load_balance_assign_core #(
    parameter int MAX_JOBS  = 64,
    parameter int MAX_PROCS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [glba_pkg::PROCS_W-1:0]       cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [glba_pkg::WEIGHT_W-1:0]      job_weight,
    input  logic                               last_job,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [glba_pkg::JOB_INDEX_W-1:0]   job_index,
    output logic [glba_pkg::WORKER_W-1:0]      worker,
    output logic                               dropped_jobs,
    output logic                               last_result
);

    localparam int IW     = $clog2(MAX_JOBS);
    localparam int CW     = $clog2(MAX_JOBS + 1);
    localparam int WID    = $clog2(MAX_PROCS);
    localparam int PCW    = $clog2(MAX_PROCS + 1);
    localparam int LW     = glba_pkg::LOAD_W;
    localparam int IDX_W  = glba_pkg::JOB_INDEX_W;
    localparam int WRK_W  = glba_pkg::WORKER_W;
    localparam int PRC_W  = glba_pkg::PROCS_W;

    glba_pkg::state_t state_reg, state_next;

    logic [PRC_W-1:0]   num_procs_reg;
    logic [CW-1:0]      count_reg;
    logic               overflow_reg;
    logic [IW-1:0]      i_reg, j_reg, k_reg;
    logic [PCW-1:0]     w_reg;
    logic [WID-1:0]     best_reg;
    logic [LW-1:0]      best_load_reg;
    logic [LW-1:0]      load_reg [MAX_PROCS];

    glba_pkg::job_entry_t cur_reg;
    glba_pkg::job_entry_t rd_reg;
    logic [WID-1:0]       asn_rd_reg;

    glba_pkg::job_entry_t order_mem [MAX_JOBS];
    logic [WID-1:0]       assign_mem [MAX_JOBS];

    // memory port controls
    logic                 mem_we, mem_re;
    logic [IW-1:0]        mem_waddr, mem_raddr;
    glba_pkg::job_entry_t mem_wdata;
    logic                 asn_we, asn_re;
    logic [IW-1:0]        asn_waddr;

    logic [PCW-1:0] procs_eff;
    logic [CW-1:0]  count_m1;
    logic           store_room;
    logic           i_more, j_end, k_end, swap;
    logic           scan_more, scan_better;
    logic [LW-1:0]  scan_load;

    // clamp num_procs to 2..MAX_PROCS
    always_comb
    begin
        priority if (num_procs_reg < PRC_W'(2))
            procs_eff = PCW'(2);
        else if (num_procs_reg > PRC_W'(MAX_PROCS))
            procs_eff = PCW'(MAX_PROCS);
        else
            procs_eff = PCW'(num_procs_reg);
    end

    assign count_m1    = count_reg - CW'(1);
    assign store_room  = count_reg < CW'(MAX_JOBS);
    assign i_more      = (CW'(i_reg) + CW'(1)) < count_reg;
    assign j_end       = j_reg == (i_reg + IW'(1));
    assign k_end       = (CW'(k_reg) + CW'(1)) == count_reg;
    assign swap        = cur_reg.weight < rd_reg.weight;
    assign scan_more   = w_reg < procs_eff;
    assign scan_load   = load_reg[w_reg[WID-1:0]];
    assign scan_better = scan_load < best_load_reg;

    assign cfg_ready    = 1'b1;
    assign job_index    = IDX_W'(k_reg);
    assign worker       = WRK_W'(asn_rd_reg);
    assign dropped_jobs = overflow_reg;
    assign last_result  = k_end;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            glba_pkg::ST_IDLE:
                if (in_valid && last_job)
                    state_next = glba_pkg::ST_SORT_I;
            glba_pkg::ST_SORT_I:
                state_next = i_more ? glba_pkg::ST_SORT_CUR : glba_pkg::ST_ASN_READ;
            glba_pkg::ST_SORT_CUR:
                state_next = glba_pkg::ST_SORT_CMP;
            glba_pkg::ST_SORT_CMP:
                if (j_end)
                    state_next = glba_pkg::ST_SORT_WB;
            glba_pkg::ST_SORT_WB:
                state_next = glba_pkg::ST_SORT_I;
            glba_pkg::ST_ASN_READ:
                state_next = glba_pkg::ST_ASN_LOAD;
            glba_pkg::ST_ASN_LOAD:
                state_next = glba_pkg::ST_ASN_SCAN;
            glba_pkg::ST_ASN_SCAN:
                if (!scan_more)
                    state_next = glba_pkg::ST_ASN_UPDATE;
            glba_pkg::ST_ASN_UPDATE:
                state_next = k_end ? glba_pkg::ST_OUT_READ : glba_pkg::ST_ASN_READ;
            glba_pkg::ST_OUT_READ:
                state_next = glba_pkg::ST_OUT_SHOW;
            glba_pkg::ST_OUT_SHOW:
                if (out_ready)
                    state_next = k_end ? glba_pkg::ST_IDLE : glba_pkg::ST_OUT_READ;
            default:
                state_next = glba_pkg::ST_IDLE;
        endcase
    end

    // handshake and memory port outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = i_reg;
        mem_raddr = i_reg;
        mem_wdata = cur_reg;
        asn_we    = 1'b0;
        asn_re    = 1'b0;
        asn_waddr = rd_reg.idx[IW-1:0];
        unique case (state_reg)
            glba_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && store_room)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = count_reg[IW-1:0];
                    mem_wdata.idx    = IDX_W'(count_reg);
                    mem_wdata.weight = job_weight;
                end
            end
            glba_pkg::ST_SORT_I:
                mem_re = i_more;
            glba_pkg::ST_SORT_CUR:
            begin
                mem_re    = 1'b1;
                mem_raddr = count_m1[IW-1:0];
            end
            glba_pkg::ST_SORT_CMP:
            begin
                // write back the displaced entry, fetch the next one down
                mem_we    = swap;
                mem_waddr = j_reg;
                mem_re    = !j_end;
                mem_raddr = j_reg - IW'(1);
            end
            glba_pkg::ST_SORT_WB:
                mem_we = 1'b1;
            glba_pkg::ST_ASN_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = k_reg;
            end
            glba_pkg::ST_ASN_LOAD,
            glba_pkg::ST_ASN_SCAN:
                mem_re = 1'b0;
            glba_pkg::ST_ASN_UPDATE:
                asn_we = 1'b1;
            glba_pkg::ST_OUT_READ:
                asn_re = 1'b1;
            glba_pkg::ST_OUT_SHOW:
                out_valid = 1'b1;
            default:
                in_ready = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= glba_pkg::ST_IDLE;
            num_procs_reg <= glba_pkg::PROCS_RESET;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            w_reg         <= '0;
            best_reg      <= '0;
            for (int p = 0; p < MAX_PROCS; p++)
                load_reg[p] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                num_procs_reg <= cfg_data;
            unique case (state_reg)
                glba_pkg::ST_IDLE:
                    if (in_valid)
                    begin
                        if (store_room)
                            count_reg <= count_reg + CW'(1);
                        else
                            overflow_reg <= 1'b1;
                        i_reg <= '0;
                    end
                glba_pkg::ST_SORT_I:
                    k_reg <= '0;
                glba_pkg::ST_SORT_CUR:
                    j_reg <= count_m1[IW-1:0];
                glba_pkg::ST_SORT_CMP:
                    if (!j_end)
                        j_reg <= j_reg - IW'(1);
                glba_pkg::ST_SORT_WB:
                    i_reg <= i_reg + IW'(1);
                glba_pkg::ST_ASN_LOAD:
                begin
                    best_reg <= WID'(1);
                    w_reg    <= PCW'(2);
                end
                glba_pkg::ST_ASN_SCAN:
                    if (scan_more)
                    begin
                        if (scan_better)
                            best_reg <= w_reg[WID-1:0];
                        w_reg <= w_reg + PCW'(1);
                    end
                glba_pkg::ST_ASN_UPDATE:
                begin
                    load_reg[best_reg] <= best_load_reg + LW'(rd_reg.weight);
                    k_reg              <= k_end ? '0 : k_reg + IW'(1);
                end
                glba_pkg::ST_OUT_SHOW:
                    if (out_ready)
                    begin
                        if (k_end)
                        begin
                            count_reg    <= '0;
                            overflow_reg <= 1'b0;
                            for (int p = 0; p < MAX_PROCS; p++)
                                load_reg[p] <= '0;
                        end
                        else
                            k_reg <= k_reg + IW'(1);
                    end
                default:
                    k_reg <= k_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            glba_pkg::ST_SORT_CUR:
                cur_reg <= rd_reg;
            glba_pkg::ST_SORT_CMP:
                if (swap)
                    cur_reg <= rd_reg;
            glba_pkg::ST_ASN_LOAD:
                best_load_reg <= load_reg[1];
            glba_pkg::ST_ASN_SCAN:
                if (scan_more && scan_better)
                    best_load_reg <= scan_load;
            default:
                cur_reg <= cur_reg;
        endcase
    end

    // job memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            order_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_reg <= order_mem[mem_raddr];
    end

    // assignment memory
    always_ff @(posedge clk)
    begin
        if (asn_we)
            assign_mem[asn_waddr] <= best_reg;
        if (asn_re)
            asn_rd_reg <= assign_mem[k_reg];
    end

endmodule

/* src/glba_checker.sv */
// port level checks for the greedy load balancing assigner, with its bind
`include "greedy_load_balance_assign_core_defines.svh"

module glba_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [glba_pkg::JOB_INDEX_W-1:0]  job_index,
    input logic [glba_pkg::WORKER_W-1:0]     worker,
    input logic                              last_result
);

    // a stalled result holds
    `GLBA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(job_index) && $stable(worker), "stalled result changed")

    // no new request is taken while results of a batch are pending
    `GLBA_ASSERT_ALWAYS(a_busy_excl, !(in_ready && out_valid), "in_ready while a result is shown")

    // worker 0 never receives a job
    `GLBA_ASSERT(a_worker_nonzero, out_valid |-> worker != '0, "job assigned to worker 0")

    // the block returns to idle once the final result is taken
    `GLBA_ASSERT(a_batch_end, out_valid && out_ready && last_result |=> in_ready && !out_valid, "not idle after the final result")

endmodule

bind greedy_load_balance_assign_core glba_checker u_glba_checker (.*);

/* tb/sv/greedy_load_balance_assign_core_tb.sv */
// self-checking testbench for the greedy load balancing job assigner
`timescale 1ns / 1ps

module greedy_load_balance_assign_core_tb;

    localparam int MAX_JOBS      = 64;
    localparam int MAX_PROCS     = 16;
    localparam int ITEMS         = 170;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 50;
    localparam int STALL_LIMIT   = 40000;

    typedef enum {ROW_JOB, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                     kind;
        logic [glba_pkg::WEIGHT_W-1:0] value;
        bit                            last;
        bit                            typed;
        logic [glba_pkg::WORKER_W-1:0] typed_worker;
    } dir_row_t;

    typedef struct packed {
        logic [glba_pkg::JOB_INDEX_W-1:0] job_index;
        logic [glba_pkg::WORKER_W-1:0]    worker;
        logic                             dropped;
        logic                             last;
    } assignment_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [glba_pkg::PROCS_W-1:0]     cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [glba_pkg::WEIGHT_W-1:0]    job_weight = '0;
    logic                             last_job = 1'b0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [glba_pkg::JOB_INDEX_W-1:0] job_index;
    logic [glba_pkg::WORKER_W-1:0]    worker;
    logic                             dropped_jobs;
    logic                             last_result;

    // predictor state
    logic [glba_pkg::WEIGHT_W-1:0] model_weight [MAX_JOBS];
    int                            model_job_count = 0;
    bit                            model_overflow = 1'b0;
    logic [glba_pkg::PROCS_W-1:0]  model_procs = glba_pkg::PROCS_RESET;

    assignment_t pending_assignments [$];
    int          mismatch_count = 0;
    int          jobs_sent = 0;
    int          burst_left = 0;
    int          stall_cycles = 0;
    bit          hold_req = 1'b0;

    // single-job batches give job 0 on worker 1 whatever the process count
    dir_row_t directed_rows [$] = '{
        '{ROW_JOB, 31'h7FFF_FFFF, 1'b1, 1'b1, 4'd1},
        '{ROW_JOB, 31'h0000_0000, 1'b1, 1'b1, 4'd1},
        '{ROW_CFG, 31'd0,         1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h0000_0001, 1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h0000_0002, 1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h4000_0000, 1'b1, 1'b0, 4'd0},
        '{ROW_CFG, 31'd31,        1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h7FFF_FFFF, 1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h7FFF_FFFF, 1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h0000_0005, 1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h0000_0005, 1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h0000_0000, 1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h0000_0000, 1'b1, 1'b0, 4'd0},
        '{ROW_CFG, 31'd3,         1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'd10,        1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'd10,        1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'd7,         1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'd3,         1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'd3,         1'b1, 1'b0, 4'd0},
        '{ROW_CFG, 31'd17,        1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h2AAA_AAAA, 1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h5555_5555, 1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h0000_0001, 1'b1, 1'b0, 4'd0},
        '{ROW_CFG, 31'd4,         1'b0, 1'b0, 4'd0},
        '{ROW_JOB, 31'h7FFF_FFFF, 1'b1, 1'b1, 4'd1}
    };

    greedy_load_balance_assign_core #(
        .MAX_JOBS  (MAX_JOBS),
        .MAX_PROCS (MAX_PROCS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .job_weight   (job_weight),
        .last_job     (last_job),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .job_index    (job_index),
        .worker       (worker),
        .dropped_jobs (dropped_jobs),
        .last_result  (last_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // store one job; on the last one sort by decreasing weight, place each job
    // on the least loaded worker and return one assignment per stored job
    function automatic void lpt_accept_job(input logic [glba_pkg::WEIGHT_W-1:0] weight,
                                           input bit last,
                                           ref assignment_t batch_out [$]);
        int                            order [MAX_JOBS];
        logic [glba_pkg::LOAD_W-1:0]   load [MAX_PROCS];
        logic [glba_pkg::WORKER_W-1:0] placed [MAX_JOBS];
        assignment_t                   r;
        int                            n;
        int                            procs;
        int                            best;
        int                            tmp;
        batch_out.delete();
        if (model_job_count < MAX_JOBS)
        begin
            model_weight[model_job_count] = weight;
            model_job_count++;
        end
        else
            model_overflow = 1'b1;
        if (!last)
            return;
        n = model_job_count;
        for (int i = 0; i < n; i++)
            order[i] = i;
        // exchange sort exactly as the block does it, ties included
        for (int i = 0; i < n; i++)
            for (int j = n - 1; j > i; j--)
                if (model_weight[order[i]] < model_weight[order[j]])
                begin
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
        procs = (model_procs < 2) ? 2 :
                (model_procs > MAX_PROCS) ? MAX_PROCS : int'(model_procs);
        for (int k = 0; k < MAX_PROCS; k++)
            load[k] = '0;
        for (int i = 0; i < n; i++)
        begin
            best = 1;
            for (int wk = 2; wk < procs; wk++)
                if (load[wk] < load[best])
                    best = wk;
            placed[order[i]] = glba_pkg::WORKER_W'(best);
            load[best] = load[best] + glba_pkg::LOAD_W'(model_weight[order[i]]);
        end
        for (int k = 0; k < n; k++)
        begin
            r.job_index = glba_pkg::JOB_INDEX_W'(k);
            r.worker    = placed[k];
            r.dropped   = model_overflow;
            r.last      = (k == n - 1);
            batch_out.push_back(r);
        end
        model_job_count = 0;
        model_overflow = 1'b0;
    endfunction

    function automatic logic [glba_pkg::WEIGHT_W-1:0] pick_weight();
        unique case ($urandom_range(0, 5))
            0: return '0;
            1: return {glba_pkg::WEIGHT_W{1'b1}};
            2, 3: return glba_pkg::WEIGHT_W'($urandom_range(0, 7));
            default: return glba_pkg::WEIGHT_W'($urandom);
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_job(input logic [glba_pkg::WEIGHT_W-1:0] weight, input bit last,
                            input bit typed,
                            input logic [glba_pkg::WORKER_W-1:0] typed_worker);
        assignment_t batch_out [$];
        assignment_t r;
        in_valid   <= 1'b1;
        job_weight <= weight;
        last_job   <= last;
        do
            @(posedge clk);
        while (!in_ready);
        jobs_sent++;
        lpt_accept_job(weight, last, batch_out);
        if (typed)
        begin
            r.job_index = '0;
            r.worker    = typed_worker;
            r.dropped   = 1'b0;
            r.last      = 1'b1;
            pending_assignments.push_back(r);
        end
        else
            foreach (batch_out[k])
                pending_assignments.push_back(batch_out[k]);
        @(negedge clk);
    endtask

    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic send_batch(input int size);
        for (int i = 0; i < size; i++)
        begin
            send_job(pick_weight(), i == size - 1, 1'b0, '0);
            pace_sender();
        end
    endtask

    // only written once the last batch has fully drained
    task automatic write_procs(input logic [glba_pkg::PROCS_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_assignments.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_procs = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input assignment_t want,
                                 input assignment_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: %s exp idx=%0d wrk=%0d drop=%0b last=%0b",
                      " got idx=%0d wrk=%0d drop=%0b last=%0b"},
                     $realtime, what, want.job_index, want.worker, want.dropped, want.last,
                     got.job_index, got.worker, got.dropped, got.last);
    endtask

    always @(posedge clk)
    begin : result_check
        assignment_t want;
        assignment_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{job_index, worker, dropped_jobs, last_result};
            if (pending_assignments.size() == 0)
                note_mismatch("unexpected result", '0, got);
            else
            begin
                want = pending_assignments.pop_front();
                if (got.job_index !== want.job_index || got.worker !== want.worker ||
                    got.dropped !== want.dropped || got.last !== want.last)
                    note_mismatch("assignment mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: switches between randomly chosen stall patterns
    initial
    begin : receiver
        int tick;
        int mode;
        tick = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (tick % 48 == 0)
                    mode = $urandom_range(0, 3);
                tick++;
                unique case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (tick % 8 >= 3);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        int batches;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
                write_procs(glba_pkg::PROCS_W'(directed_rows[r].value));
            else
            begin
                send_job(directed_rows[r].value, directed_rows[r].last,
                         directed_rows[r].typed, directed_rows[r].typed_worker);
                pace_sender();
            end
        end

        phase = 0;
        while (jobs_sent < ITEMS || phase <= 4)
        begin
            unique case (phase)
                2: write_procs(glba_pkg::PROCS_W'(MAX_PROCS));
                4: write_procs(5'd9);
                default: write_procs(glba_pkg::PROCS_W'($urandom_range(0, 31)));
            endcase
            if (phase == 2)
                send_batch(MAX_JOBS);
            else if (phase == 4)
                send_batch(MAX_JOBS + 1);   // store full, last request dropped
            else
            begin
                batches = (phase == 1) ? 3 : $urandom_range(1, 3);
                // results back up so the next batch waits at the input
                if (phase == 1)
                    hold_req = 1'b1;
                repeat (batches) send_batch($urandom_range(1, 10));
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (pending_assignments.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_assignments.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/glba_pkg.sv
src/greedy_load_balance_assign_core.sv
src/glba_checker.sv
tb/sv/greedy_load_balance_assign_core_tb.sv
